// ----- rtl/hrke_pkg.sv -----
// Shared types and constants for the HID report to key event converter.
// No dependencies.
package hrke_pkg;

    localparam int NUM_MODS = 8;
    localparam int NUM_EVTS = NUM_MODS + 2;
    localparam int EVT_IDX_W = $clog2(NUM_EVTS);

    // Slot order inside one job: modifier bits, then old-key release, then new-key press
    localparam logic [EVT_IDX_W-1:0] SLOT_RELEASE = EVT_IDX_W'(NUM_MODS);
    localparam logic [EVT_IDX_W-1:0] SLOT_PRESS   = EVT_IDX_W'(NUM_MODS + 1);

    typedef struct packed {
        logic [7:0] report_modifier;
        logic [7:0] report_usage;
    } rpt_t;

    typedef struct packed {
        logic       is_press;
        logic [6:0] key_number;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic [NUM_EVTS-1:0] pend;
        logic [NUM_MODS-1:0] mod_level;
        logic [6:0]          rel_key;
        logic [6:0]          prs_key;
    } job_t;

    function automatic logic [6:0] mod_key(input logic [2:0] bit_idx);
        logic [6:0] k;
        case (bit_idx)
            3'd0:    k = 7'd29;
            3'd1:    k = 7'd42;
            3'd2:    k = 7'd56;
            3'd3:    k = 7'd125;
            3'd4:    k = 7'd97;
            3'd5:    k = 7'd54;
            3'd6:    k = 7'd100;
            default: k = 7'd126;
        endcase
        return k;
    endfunction

    // HID usage to input-layer key code; unmapped codes give 0
    function automatic logic [6:0] usage_key(input logic [7:0] u);
        logic [6:0] k;
        case (u)
            8'h04: k = 7'd30;  8'h05: k = 7'd48;  8'h06: k = 7'd46;  8'h07: k = 7'd32;
            8'h08: k = 7'd18;  8'h09: k = 7'd33;  8'h0A: k = 7'd34;  8'h0B: k = 7'd35;
            8'h0C: k = 7'd23;  8'h0D: k = 7'd36;  8'h0E: k = 7'd37;  8'h0F: k = 7'd38;
            8'h10: k = 7'd50;  8'h11: k = 7'd49;  8'h12: k = 7'd24;  8'h13: k = 7'd25;
            8'h14: k = 7'd16;  8'h15: k = 7'd19;  8'h16: k = 7'd31;  8'h17: k = 7'd20;
            8'h18: k = 7'd22;  8'h19: k = 7'd47;  8'h1A: k = 7'd17;  8'h1B: k = 7'd45;
            8'h1C: k = 7'd21;  8'h1D: k = 7'd44;
            8'h1E: k = 7'd2;   8'h1F: k = 7'd3;   8'h20: k = 7'd4;   8'h21: k = 7'd5;
            8'h22: k = 7'd6;   8'h23: k = 7'd7;   8'h24: k = 7'd8;   8'h25: k = 7'd9;
            8'h26: k = 7'd10;  8'h27: k = 7'd11;
            8'h28: k = 7'd28;  8'h29: k = 7'd1;   8'h2A: k = 7'd14;  8'h2B: k = 7'd15;
            8'h2C: k = 7'd57;  8'h2D: k = 7'd12;  8'h2E: k = 7'd13;  8'h2F: k = 7'd26;
            8'h30: k = 7'd27;  8'h31: k = 7'd43;  8'h33: k = 7'd39;  8'h34: k = 7'd40;
            8'h35: k = 7'd41;  8'h36: k = 7'd51;  8'h37: k = 7'd52;  8'h38: k = 7'd53;
            8'h39: k = 7'd58;
            8'h3A: k = 7'd59;  8'h3B: k = 7'd60;  8'h3C: k = 7'd61;  8'h3D: k = 7'd62;
            8'h3E: k = 7'd63;  8'h3F: k = 7'd64;  8'h40: k = 7'd65;  8'h41: k = 7'd66;
            8'h42: k = 7'd67;  8'h43: k = 7'd68;  8'h44: k = 7'd87;  8'h45: k = 7'd88;
            8'h49: k = 7'd110; 8'h4A: k = 7'd102; 8'h4B: k = 7'd104; 8'h4C: k = 7'd111;
            8'h4D: k = 7'd107; 8'h4E: k = 7'd109; 8'h4F: k = 7'd106; 8'h50: k = 7'd105;
            8'h51: k = 7'd108; 8'h52: k = 7'd103;
            8'h55: k = 7'd55;
            8'h58: k = 7'd28;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/hrke_front.sv -----
// Front end: accepts reports, diffs them against held state, builds event jobs.
// Depends on hrke_pkg.
module hrke_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rpt_valid,
    output logic          rpt_stall,
    input  hrke_pkg::rpt_t rpt,
    output logic          push,
    output hrke_pkg::job_t push_job,
    input  logic          q_full
);
    import hrke_pkg::*;

    logic [7:0] held_mask_reg;
    logic [7:0] held_usage_reg;
    logic       accept;
    logic       usage_chg;
    logic [6:0] old_key;
    logic [6:0] new_key;

    assign rpt_stall = q_full;
    assign accept    = rpt_valid && !q_full;

    assign usage_chg = rpt.report_usage != held_usage_reg;
    assign old_key   = usage_key(held_usage_reg);
    assign new_key   = usage_key(rpt.report_usage);

    always_comb
    begin
        push_job.mod_level            = rpt.report_modifier;
        push_job.rel_key              = old_key;
        push_job.prs_key              = new_key;
        push_job.pend[NUM_MODS-1:0]   = rpt.report_modifier ^ held_mask_reg;
        // usage_key(0) is 0, so a zero code never yields an event
        push_job.pend[SLOT_RELEASE]   = usage_chg && (old_key != 7'd0);
        push_job.pend[SLOT_PRESS]     = usage_chg && (new_key != 7'd0);
    end

    // Reports with no difference produce no job
    assign push = accept && (push_job.pend != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mask_reg  <= '0;
            held_usage_reg <= '0;
        end
        else if (accept)
        begin
            held_mask_reg  <= rpt.report_modifier;
            held_usage_reg <= rpt.report_usage;
        end
    end

endmodule

// ----- rtl/hrke_queue.sv -----
// Two-entry job queue between front and back ends.
// Depends on hrke_pkg.
module hrke_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrke_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output hrke_pkg::job_t head
);
    import hrke_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/hrke_back.sv -----
// Back end: walks the head job's pending slots, one event beat per cycle unless stalled.
// Depends on hrke_pkg.
module hrke_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  hrke_pkg::job_t head,
    output logic           pop,
    output logic           evt_valid,
    input  logic           evt_stall,
    output hrke_pkg::evt_t evt
);
    import hrke_pkg::*;

    logic [NUM_EVTS-1:0]  pend_reg;
    logic [NUM_EVTS-1:0]  pend_next;
    logic                 mid_job_reg;
    logic                 mid_job_next;
    logic                 evt_valid_reg;
    logic                 evt_valid_next;
    evt_t                 evt_reg;
    evt_t                 evt_next;
    logic [NUM_EVTS-1:0]  active;
    logic [NUM_EVTS-1:0]  remain;
    logic [EVT_IDX_W-1:0] idx;
    logic                 advance;
    logic                 fire;

    // Once part of the head job is sent, the remaining slots live in pend_reg
    assign active  = mid_job_reg ? pend_reg : head.pend;
    assign advance = !evt_valid_reg || !evt_stall;
    assign fire    = advance && q_not_empty;

    always_comb
    begin
        idx = '0;
        for (int i = NUM_EVTS - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                idx = EVT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        remain = active;
        remain[idx] = 1'b0;
        pop = fire && (remain == '0);

        if (idx == SLOT_RELEASE)
        begin
            evt_next.is_press   = 1'b0;
            evt_next.key_number = head.rel_key;
        end
        else if (idx == SLOT_PRESS)
        begin
            evt_next.is_press   = 1'b1;
            evt_next.key_number = head.prs_key;
        end
        else
        begin
            evt_next.is_press   = head.mod_level[idx[2:0]];
            evt_next.key_number = mod_key(idx[2:0]);
        end
        evt_next.last_event = remain == '0;

        pend_next      = pend_reg;
        mid_job_next   = mid_job_reg;
        evt_valid_next = evt_valid_reg;
        if (advance)
        begin
            evt_valid_next = q_not_empty;
        end
        if (fire)
        begin
            pend_next    = remain;
            mid_job_next = remain != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            mid_job_reg   <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            mid_job_reg   <= mid_job_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            evt_reg <= evt_next;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

// ----- rtl/hid_report_to_key_events.sv -----
// Keyboard report to key event converter, top level.
// Path: an accepted report's job is written into the queue, then its event beats are registered at the output.
// Throughput: one event beat per cycle from the back end while evt_stall is low; a report's
// events go out one per beat, and a two-job queue lets reports keep arriving until it is full.
// Reset: asynchronous active-low; clears held mask/usage, queue and output valid.
module hid_report_to_key_events (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rpt_valid,
    output logic           rpt_stall,
    input  hrke_pkg::rpt_t rpt,
    output logic           evt_valid,
    input  logic           evt_stall,
    output hrke_pkg::evt_t evt
);
    import hrke_pkg::*;

    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic q_not_empty;
    job_t head;

    hrke_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    hrke_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    hrke_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt         (evt)
    );

endmodule
